// File: rtl/oavd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// OAM / VRAM DMA package
// Shared types and constants: request codes, decoded commands, result kinds,
// register addresses and queue sizes.
// ----------------------------------------------------------------------------
package oavd_pkg;

    // Request codes on req_type
    localparam logic [1:0] REQ_TICK      = 2'd0;
    localparam logic [1:0] REQ_OAM_START = 2'd1;
    localparam logic [1:0] REQ_WRITE     = 2'd2;
    localparam logic [1:0] REQ_READ      = 2'd3;

    // Result kinds on result_kind
    localparam logic [1:0] KIND_OAM_COPY = 2'd0;
    localparam logic [1:0] KIND_BUS_COPY = 2'd1;
    localparam logic [1:0] KIND_READ     = 2'd2;

    // Decoded register addresses
    localparam logic [15:0] ADDR_SRC_HI = 16'hFF51;
    localparam logic [15:0] ADDR_SRC_LO = 16'hFF52;
    localparam logic [15:0] ADDR_DST_HI = 16'hFF53;
    localparam logic [15:0] ADDR_DST_LO = 16'hFF54;
    localparam logic [15:0] ADDR_LENGTH = 16'hFF55;

    // Register field masks and fixed values
    localparam logic [7:0]  SRC_LO_MASK   = 8'hF0;
    localparam logic [7:0]  DST_HI_MASK   = 8'h1F;
    localparam logic [7:0]  DST_LO_MASK   = 8'hF0;
    localparam logic [7:0]  LEN_MASK      = 8'h7F;
    localparam logic [7:0]  LEN_IDLE_BIT  = 8'h80;
    localparam logic [7:0]  LEN_DONE      = 8'hFF;
    localparam logic [7:0]  READ_UNMAPPED = 8'hFF;
    localparam logic [15:0] DST_BASE      = 16'h8000;

    // Queue sizes
    localparam int CMD_DEPTH = 4;
    localparam int CMD_AW    = $clog2(CMD_DEPTH);
    localparam int CMD_CW    = $clog2(CMD_DEPTH + 1);
    localparam int RES_DEPTH = 4;
    localparam int RES_AW    = $clog2(RES_DEPTH);
    localparam int RES_CW    = $clog2(RES_DEPTH + 1);

    // Decoded operations passed from front to back
    typedef enum logic [3:0] {
        OP_TICK        = 4'd0,
        OP_OAM_START   = 4'd1,
        OP_SRC_HI      = 4'd2,
        OP_SRC_LO      = 4'd3,
        OP_DST_HI      = 4'd4,
        OP_DST_LO      = 4'd5,
        OP_LENGTH      = 4'd6,
        OP_READ_STATUS = 4'd7,
        OP_READ_OTHER  = 4'd8
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] data;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] src;
        logic [15:0] dst;
        logic [7:0]  value;
        logic        busy;
        logic        last;
    } res_t;

    // Write side of the result queue
    typedef struct packed {
        logic wr0;
        logic wr1;
        res_t res0;
        res_t res1;
    } res_wr_t;

endpackage

// File: rtl/oavd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// OAM / VRAM DMA front end
// Decodes incoming requests into commands and queues them for the back end.
// Writes to undecoded addresses are dropped here.
// ----------------------------------------------------------------------------
module oavd_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic [1:0]          req_type,
    input  logic [15:0]         reg_address,
    input  logic [7:0]          data_byte,
    output logic                cmd_valid,
    output oavd_pkg::cmd_t      cmd,
    input  logic                cmd_pop
);

    oavd_pkg::cmd_t                  mem_reg [oavd_pkg::CMD_DEPTH];
    logic [oavd_pkg::CMD_AW-1:0]     wr_ptr_reg;
    logic [oavd_pkg::CMD_AW-1:0]     rd_ptr_reg;
    logic [oavd_pkg::CMD_CW-1:0]     count_reg;
    logic [oavd_pkg::CMD_CW-1:0]     count_next;
    oavd_pkg::cmd_t                  dec_cmd;
    logic                            dec_keep;
    logic                            enq;
    logic                            deq;

    // Classify the request
    always_comb
    begin
        dec_cmd.op   = oavd_pkg::OP_TICK;
        dec_cmd.data = data_byte;
        dec_keep     = 1'b1;
        unique case (req_type)
            oavd_pkg::REQ_TICK:      dec_cmd.op = oavd_pkg::OP_TICK;
            oavd_pkg::REQ_OAM_START: dec_cmd.op = oavd_pkg::OP_OAM_START;
            oavd_pkg::REQ_WRITE:
            begin
                unique case (reg_address)
                    oavd_pkg::ADDR_SRC_HI: dec_cmd.op = oavd_pkg::OP_SRC_HI;
                    oavd_pkg::ADDR_SRC_LO: dec_cmd.op = oavd_pkg::OP_SRC_LO;
                    oavd_pkg::ADDR_DST_HI: dec_cmd.op = oavd_pkg::OP_DST_HI;
                    oavd_pkg::ADDR_DST_LO: dec_cmd.op = oavd_pkg::OP_DST_LO;
                    oavd_pkg::ADDR_LENGTH: dec_cmd.op = oavd_pkg::OP_LENGTH;
                    default:               dec_keep   = 1'b0;
                endcase
            end
            oavd_pkg::REQ_READ:
            begin
                if (reg_address == oavd_pkg::ADDR_LENGTH)
                    dec_cmd.op = oavd_pkg::OP_READ_STATUS;
                else
                    dec_cmd.op = oavd_pkg::OP_READ_OTHER;
            end
            default:                 dec_keep   = 1'b0;
        endcase
    end

    assign full      = (count_reg == oavd_pkg::CMD_CW'(oavd_pkg::CMD_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = mem_reg[rd_ptr_reg];
    assign enq       = push && !full && dec_keep;
    assign deq       = cmd_pop && cmd_valid;

    always_comb
    begin
        count_next = count_reg;
        if (enq && !deq)
            count_next = count_reg + 1'b1;
        else if (!enq && deq)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (enq)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (deq)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enq)
            mem_reg[wr_ptr_reg] <= dec_cmd;
    end

endmodule

// File: rtl/oavd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// OAM / VRAM DMA back end
// Holds the DMA state, executes one command per cycle while the result
// queue has room for two entries and produces up to two results per tick.
// ----------------------------------------------------------------------------
module oavd_back
#(
    parameter int OAM_BYTES      = 160,
    parameter int OAM_LEAD_TICKS = 2,
    parameter int BLOCK_BYTES    = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    input  oavd_pkg::cmd_t      cmd,
    output logic                cmd_pop,
    input  logic                res_room,
    output oavd_pkg::res_wr_t   res_wr
);

    logic        oam_running_reg,    oam_running_next;
    logic [7:0]  oam_index_reg,      oam_index_next;
    logic [7:0]  oam_page_reg,       oam_page_next;
    logic [1:0]  oam_delay_reg,      oam_delay_next;
    logic [15:0] vram_source_reg,    vram_source_next;
    logic [15:0] vram_target_reg,    vram_target_next;
    logic [7:0]  length_status_reg,  length_status_next;
    logic        hblank_flag_reg,    hblank_flag_next;
    logic [11:0] gen_left_reg,       gen_left_next;
    logic [10:0] gen_offset_reg,     gen_offset_next;

    logic           oam_emit;
    logic           gen_emit;
    logic           busy_next;
    logic [8:0]     oam_index_inc;
    oavd_pkg::res_t oam_res;
    oavd_pkg::res_t gen_res;
    oavd_pkg::res_t read_res;

    assign cmd_pop = cmd_valid && res_room;

    assign oam_index_inc = {1'b0, oam_index_reg} + 9'd1;

    always_comb
    begin
        oam_res       = '0;
        oam_res.kind  = oavd_pkg::KIND_OAM_COPY;
        oam_res.src   = {oam_page_reg, oam_index_reg};
        oam_res.dst   = {8'd0, oam_index_reg};
        gen_res       = '0;
        gen_res.kind  = oavd_pkg::KIND_BUS_COPY;
        gen_res.src   = vram_source_reg + {5'd0, gen_offset_reg};
        gen_res.dst   = vram_target_reg + {5'd0, gen_offset_reg};
        read_res      = '0;
        read_res.kind = oavd_pkg::KIND_READ;
        read_res.value = oavd_pkg::READ_UNMAPPED;
    end

    // State update for the command at the head of the queue
    always_comb
    begin
        oam_running_next   = oam_running_reg;
        oam_index_next     = oam_index_reg;
        oam_page_next      = oam_page_reg;
        oam_delay_next     = oam_delay_reg;
        vram_source_next   = vram_source_reg;
        vram_target_next   = vram_target_reg;
        length_status_next = length_status_reg;
        hblank_flag_next   = hblank_flag_reg;
        gen_left_next      = gen_left_reg;
        gen_offset_next    = gen_offset_reg;
        oam_emit           = 1'b0;
        gen_emit           = 1'b0;
        res_wr             = '0;

        if (cmd_pop)
        begin
            unique case (cmd.op)
                oavd_pkg::OP_TICK:
                begin
                    if (oam_running_reg)
                    begin
                        if (oam_delay_reg != 2'd0)
                            oam_delay_next = oam_delay_reg - 2'd1;
                        else
                        begin
                            oam_emit         = 1'b1;
                            oam_index_next   = oam_index_inc[7:0];
                            oam_running_next = (oam_index_inc < 9'(OAM_BYTES));
                        end
                    end
                    if (gen_left_reg != 12'd0)
                    begin
                        gen_emit        = 1'b1;
                        gen_offset_next = gen_offset_reg + 11'd1;
                        gen_left_next   = gen_left_reg - 12'd1;
                    end
                end
                oavd_pkg::OP_OAM_START:
                begin
                    oam_running_next = 1'b1;
                    oam_index_next   = 8'd0;
                    oam_delay_next   = 2'(OAM_LEAD_TICKS);
                    oam_page_next    = cmd.data;
                end
                oavd_pkg::OP_SRC_HI:
                    vram_source_next = {cmd.data, vram_source_reg[7:0]};
                oavd_pkg::OP_SRC_LO:
                    vram_source_next = {vram_source_reg[15:8], cmd.data & oavd_pkg::SRC_LO_MASK};
                oavd_pkg::OP_DST_HI:
                    vram_target_next = oavd_pkg::DST_BASE
                                     | {cmd.data & oavd_pkg::DST_HI_MASK, vram_target_reg[7:0]};
                oavd_pkg::OP_DST_LO:
                    vram_target_next = oavd_pkg::DST_BASE
                                     | {vram_target_reg[15:8], cmd.data & oavd_pkg::DST_LO_MASK};
                oavd_pkg::OP_LENGTH:
                begin
                    if (hblank_flag_reg && !cmd.data[7])
                    begin
                        hblank_flag_next   = 1'b0;
                        length_status_next = oavd_pkg::LEN_DONE;
                    end
                    else if (cmd.data[7])
                    begin
                        length_status_next = cmd.data & oavd_pkg::LEN_MASK;
                        hblank_flag_next   = 1'b1;
                    end
                    else
                    begin
                        gen_left_next      = 12'(({5'd0, cmd.data[6:0]} + 12'd1)
                                                 * 12'(BLOCK_BYTES));
                        gen_offset_next    = 11'd0;
                        length_status_next = oavd_pkg::LEN_DONE;
                    end
                end
                oavd_pkg::OP_READ_STATUS:
                begin
                    res_wr.wr0        = 1'b1;
                    res_wr.res0       = read_res;
                    res_wr.res0.value = (hblank_flag_reg ? 8'd0 : oavd_pkg::LEN_IDLE_BIT)
                                      | length_status_reg;
                end
                oavd_pkg::OP_READ_OTHER:
                begin
                    res_wr.wr0  = 1'b1;
                    res_wr.res0 = read_res;
                end
                default: ;
            endcase

            // Order the tick results: OAM copy first, bus copy second
            if (oam_emit)
            begin
                res_wr.wr0  = 1'b1;
                res_wr.res0 = oam_res;
                if (gen_emit)
                begin
                    res_wr.wr1  = 1'b1;
                    res_wr.res1 = gen_res;
                end
            end
            else if (gen_emit)
            begin
                res_wr.wr0  = 1'b1;
                res_wr.res0 = gen_res;
            end
        end

        busy_next = oam_running_next || hblank_flag_next || (gen_left_next != 12'd0);
        res_wr.res0.busy = busy_next;
        res_wr.res1.busy = busy_next;
        res_wr.res0.last = !res_wr.wr1;
        res_wr.res1.last = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oam_running_reg   <= 1'b0;
            oam_index_reg     <= 8'd0;
            oam_page_reg      <= 8'd0;
            oam_delay_reg     <= 2'd0;
            vram_source_reg   <= 16'd0;
            vram_target_reg   <= 16'd0;
            length_status_reg <= 8'd0;
            hblank_flag_reg   <= 1'b0;
            gen_left_reg      <= 12'd0;
            gen_offset_reg    <= 11'd0;
        end
        else
        begin
            oam_running_reg   <= oam_running_next;
            oam_index_reg     <= oam_index_next;
            oam_page_reg      <= oam_page_next;
            oam_delay_reg     <= oam_delay_next;
            vram_source_reg   <= vram_source_next;
            vram_target_reg   <= vram_target_next;
            length_status_reg <= length_status_next;
            hblank_flag_reg   <= hblank_flag_next;
            gen_left_reg      <= gen_left_next;
            gen_offset_reg    <= gen_offset_next;
        end
    end

`ifndef SYNTH
    a_oam_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        oam_running_reg |-> ({1'b0, oam_index_reg} < 9'(OAM_BYTES)))
        else $error("OAM index beyond table while copy runs");

    a_gen_left_range: assert property (@(posedge clk) disable iff (!rst_n)
        gen_left_reg <= 12'(128 * BLOCK_BYTES))
        else $error("general copy length beyond maximum");
`endif

endmodule

// File: rtl/oavd_res_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// OAM / VRAM DMA result queue
// Small result queue taking up to two entries per cycle and giving one.
// ----------------------------------------------------------------------------
module oavd_res_fifo
(
    input  logic                clk,
    input  logic                rst_n,
    input  oavd_pkg::res_wr_t   res_wr,
    output logic                res_room,
    output logic                empty,
    input  logic                pop,
    output oavd_pkg::res_t      dout
);

    oavd_pkg::res_t                  mem_reg [oavd_pkg::RES_DEPTH];
    logic [oavd_pkg::RES_AW-1:0]     wr_ptr_reg;
    logic [oavd_pkg::RES_AW-1:0]     rd_ptr_reg;
    logic [oavd_pkg::RES_CW-1:0]     count_reg;
    logic [oavd_pkg::RES_AW-1:0]     wr_ptr_p1;
    logic [1:0]                      n_wr;
    logic                            deq;

    assign empty     = (count_reg == '0);
    assign dout      = mem_reg[rd_ptr_reg];
    assign deq       = pop && !empty;
    assign res_room  = (count_reg <= oavd_pkg::RES_CW'(oavd_pkg::RES_DEPTH - 2));
    assign wr_ptr_p1 = wr_ptr_reg + 1'b1;
    assign n_wr      = {1'b0, res_wr.wr0} + {1'b0, res_wr.wr1};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + oavd_pkg::RES_AW'(n_wr);
            if (deq)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_reg + oavd_pkg::RES_CW'(n_wr)
                       - oavd_pkg::RES_CW'(deq);
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_wr.wr0)
            mem_reg[wr_ptr_reg] <= res_wr.res0;
        if (res_wr.wr1)
            mem_reg[wr_ptr_p1] <= res_wr.res1;
    end

`ifndef SYNTH
    a_wr_order: assert property (@(posedge clk) disable iff (!rst_n)
        res_wr.wr1 |-> res_wr.wr0)
        else $error("second result written without first");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (res_wr.wr0 && !res_room) |-> 1'b0)
        else $error("result queue written without room");
`endif

endmodule

// File: rtl/oam_and_vram_dma_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// OAM and VRAM DMA controller
// Top level: request decode front end, command queue, DMA state back end
// and result queue.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter through a queue-style port: a transfer happens on a clock
//   edge with push high and full low. req_type selects tick, OAM DMA start,
//   register write or register read; reg_address and data_byte qualify it.
//   Results leave through a second queue-style port: while empty is low the
//   oldest result sits on the result ports and transfers on an edge with pop
//   high. A tick gives zero, one or two results (OAM copy before bus copy);
//   a read gives one; starts and writes give none. last_of_step marks the
//   final result of a request.
//   Path: a request is registered in the command queue; the engine executes
//   it when the result queue has room and writes its results into the
//   registered result queue, whose head drives the result ports.
//   Throughput: one request per cycle while full is low; the DMA engine
//   executes one command per cycle whenever the result queue has room for
//   two entries. Results drain at one per cycle, so a stream of
//   double-result ticks runs at the pop rate.
//   Reset clears all DMA state and both queues. When the receiver stalls,
//   the result queue fills, the engine holds, then the command queue fills
//   and full rises; nothing is lost.
// ----------------------------------------------------------------------------
module oam_and_vram_dma_controller
#(
    parameter int OAM_BYTES      = 160,
    parameter int OAM_LEAD_TICKS = 2,
    parameter int BLOCK_BYTES    = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  req_type,
    input  logic [15:0] reg_address,
    input  logic [7:0]  data_byte,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  result_kind,
    output logic [15:0] source_address,
    output logic [15:0] target_address,
    output logic [7:0]  read_value,
    output logic        busy_res,
    output logic        last_of_step
);

    logic              cmd_valid;
    oavd_pkg::cmd_t    cmd;
    logic              cmd_pop;
    logic              res_room;
    oavd_pkg::res_wr_t res_wr;
    oavd_pkg::res_t    res_head;

    // Decode requests, drop undecoded writes, queue the rest
    oavd_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .req_type    (req_type),
        .reg_address (reg_address),
        .data_byte   (data_byte),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd),
        .cmd_pop     (cmd_pop)
    );

    // Execute commands against the DMA state
    oavd_back
    #(
        .OAM_BYTES      (OAM_BYTES),
        .OAM_LEAD_TICKS (OAM_LEAD_TICKS),
        .BLOCK_BYTES    (BLOCK_BYTES)
    )
    u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .res_room  (res_room),
        .res_wr    (res_wr)
    );

    // Hold results until the receiver takes them
    oavd_res_fifo u_res_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_wr   (res_wr),
        .res_room (res_room),
        .empty    (empty),
        .pop      (pop),
        .dout     (res_head)
    );

    assign result_kind    = res_head.kind;
    assign source_address = res_head.src;
    assign target_address = res_head.dst;
    assign read_value     = res_head.value;
    assign busy_res       = res_head.busy;
    assign last_of_step   = res_head.last;

endmodule
